// ===== src/alarm_table_with_expiry_unit_assert.svh =====
// Assertion macros for the alarm table with expiry unit
`ifndef ALARM_TABLE_WITH_EXPIRY_UNIT_ASSERT_SVH
`define ALARM_TABLE_WITH_EXPIRY_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ATWE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ATWE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/atwe_pkg.sv =====
// Shared types and constants for the alarm table with expiry unit
package atwe_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int OUT_CNT_W = 7;

  localparam logic [2:0] OP_ADD_ABS = 3'd0;
  localparam logic [2:0] OP_ADD_REL = 3'd1;
  localparam logic [2:0] OP_EXPIRE  = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] t_start;
    logic [31:0] t_end;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] entry_count;
    logic                 read_valid;
    entry_t               rdat;
    logic                 was_updated;
    logic                 was_evicted;
  } result_t;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SRCH_RD  = 9'b000000010,
    S_SRCH_CHK = 9'b000000100,
    S_CMP_RD   = 9'b000001000,
    S_CMP_CHK  = 9'b000010000,
    S_APPEND   = 9'b000100000,
    S_RD_ISSUE = 9'b001000000,
    S_RD_CAP   = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

endpackage

// ===== src/atwe_mem.sv =====
// Alarm table storage: one write port, one registered read port
module atwe_mem (
  input  logic               clk,
  input  atwe_pkg::mem_req_t req,
  output atwe_pkg::entry_t   rdata
);

  atwe_pkg::entry_t slots [atwe_pkg::ENTRIES];
  atwe_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      slots[req.waddr] <= req.wdata;
    end
    rdata_r <= slots[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/atwe_ctrl.sv =====
// Sequencer: id search, compaction walk, append and read over the table memory
module atwe_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_op,
  input  atwe_pkg::entry_t      in_item,
  input  logic [31:0]           in_now,
  input  logic [5:0]            in_index,
  output atwe_pkg::mem_req_t    mem_req,
  input  atwe_pkg::entry_t      mem_rdata,
  output logic                  res_done,
  output atwe_pkg::result_t     res,
  input  logic                  res_take
);

  atwe_pkg::state_t state_r, state_nxt;
  logic [atwe_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [atwe_pkg::CNT_W-1:0] ptr_r, ptr_nxt;
  logic [atwe_pkg::CNT_W-1:0] wr_r, wr_nxt;
  logic             upd_r, upd_nxt;
  logic             evi_r, evi_nxt;
  logic             rv_r, rv_nxt;
  atwe_pkg::entry_t item_r, item_nxt;
  atwe_pkg::entry_t rdat_r, rdat_nxt;
  logic [31:0]      now_r, now_nxt;

  logic             id_hit;
  logic             keep;
  logic             more;
  logic [atwe_pkg::CNT_W-1:0] ptr_inc;
  logic [atwe_pkg::CNT_W-1:0] wr_inc;

  // shared compare unit
  assign id_hit  = (mem_rdata.id == item_r.id);
  assign keep    = evi_r || (now_r <= mem_rdata.t_end);
  assign ptr_inc = ptr_r + atwe_pkg::CNT_W'(1);
  assign more    = (ptr_inc < count_r);
  assign wr_inc  = wr_r + atwe_pkg::CNT_W'(keep);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    wr_nxt    = wr_r;
    upd_nxt   = upd_r;
    evi_nxt   = evi_r;
    rv_nxt    = rv_r;
    item_nxt  = item_r;
    rdat_nxt  = rdat_r;
    now_nxt   = now_r;

    mem_req.we    = 1'b0;
    mem_req.waddr = ptr_r[atwe_pkg::IDX_W-1:0];
    mem_req.wdata = item_r;
    mem_req.raddr = ptr_r[atwe_pkg::IDX_W-1:0];

    unique case (state_r)
      atwe_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_item;
          now_nxt  = in_now;
          upd_nxt  = 1'b0;
          evi_nxt  = 1'b0;
          rv_nxt   = 1'b0;
          rdat_nxt = '0;
          ptr_nxt  = '0;
          wr_nxt   = '0;
          unique case (in_op) inside
            atwe_pkg::OP_ADD_ABS, atwe_pkg::OP_ADD_REL: begin
              state_nxt = (count_r == '0) ? atwe_pkg::S_APPEND : atwe_pkg::S_SRCH_RD;
            end
            atwe_pkg::OP_EXPIRE: begin
              state_nxt = (count_r == '0) ? atwe_pkg::S_DONE : atwe_pkg::S_CMP_RD;
            end
            atwe_pkg::OP_READ: begin
              if (8'(in_index) < 8'(count_r)) begin
                ptr_nxt   = atwe_pkg::CNT_W'(in_index);
                state_nxt = atwe_pkg::S_RD_ISSUE;
              end else begin
                state_nxt = atwe_pkg::S_DONE;
              end
            end
            atwe_pkg::OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = atwe_pkg::S_DONE;
            end
            default: begin
              state_nxt = atwe_pkg::S_DONE;
            end
          endcase
        end
      end
      atwe_pkg::S_SRCH_RD: begin
        state_nxt = atwe_pkg::S_SRCH_CHK;
      end
      atwe_pkg::S_SRCH_CHK: begin
        if (id_hit) begin
          mem_req.we = 1'b1;
          upd_nxt    = 1'b1;
          state_nxt  = atwe_pkg::S_DONE;
        end else if (more) begin
          ptr_nxt   = ptr_inc;
          state_nxt = atwe_pkg::S_SRCH_RD;
        end else if (count_r == atwe_pkg::CNT_W'(atwe_pkg::ENTRIES)) begin
          // full: drop the oldest by compacting from slot one
          evi_nxt   = 1'b1;
          ptr_nxt   = atwe_pkg::CNT_W'(1);
          wr_nxt    = '0;
          state_nxt = atwe_pkg::S_CMP_RD;
        end else begin
          state_nxt = atwe_pkg::S_APPEND;
        end
      end
      atwe_pkg::S_CMP_RD: begin
        state_nxt = atwe_pkg::S_CMP_CHK;
      end
      atwe_pkg::S_CMP_CHK: begin
        mem_req.we    = keep;
        mem_req.waddr = wr_r[atwe_pkg::IDX_W-1:0];
        mem_req.wdata = mem_rdata;
        if (more) begin
          ptr_nxt   = ptr_inc;
          wr_nxt    = wr_inc;
          state_nxt = atwe_pkg::S_CMP_RD;
        end else begin
          count_nxt = wr_inc;
          state_nxt = evi_r ? atwe_pkg::S_APPEND : atwe_pkg::S_DONE;
        end
      end
      atwe_pkg::S_APPEND: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = count_r[atwe_pkg::IDX_W-1:0];
        count_nxt     = count_r + atwe_pkg::CNT_W'(1);
        state_nxt     = atwe_pkg::S_DONE;
      end
      atwe_pkg::S_RD_ISSUE: begin
        state_nxt = atwe_pkg::S_RD_CAP;
      end
      atwe_pkg::S_RD_CAP: begin
        rv_nxt    = 1'b1;
        rdat_nxt  = mem_rdata;
        state_nxt = atwe_pkg::S_DONE;
      end
      atwe_pkg::S_DONE: begin
        if (res_take) begin
          state_nxt = atwe_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = atwe_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atwe_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    wr_r   <= wr_nxt;
    upd_r  <= upd_nxt;
    evi_r  <= evi_nxt;
    rv_r   <= rv_nxt;
    item_r <= item_nxt;
    rdat_r <= rdat_nxt;
    now_r  <= now_nxt;
  end

  assign in_stall = (state_r != atwe_pkg::S_IDLE);
  assign res_done = (state_r == atwe_pkg::S_DONE);

  always_comb begin
    res.entry_count = atwe_pkg::OUT_CNT_W'(count_r);
    res.read_valid  = rv_r;
    res.rdat        = rdat_r;
    res.was_updated = upd_r;
    res.was_evicted = evi_r;
  end

endmodule

// ===== src/alarm_table_with_expiry_unit.sv =====
// Alarm table with expiry: ordered table of up to ENTRIES alarms, one item at a time.
// Clear, expire on an empty table, out-of-range read and unused ops go straight to done;
// read issues and captures one table read; add walks the table slot by slot, and when full
// compacts out the oldest before appending; expire walks the whole table. No new item is
// taken until the result is loaded; walks are set by the table memory and shared compare unit.
// Reset: synchronous active-low; clears count and handshake state, table is unwritten.
`include "alarm_table_with_expiry_unit_assert.svh"
module alarm_table_with_expiry_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [15:0] in_alarm_id,
  input  logic [31:0] in_start_time,
  input  logic [31:0] in_end_time,
  input  logic [31:0] in_duration,
  input  logic [31:0] in_now,
  input  logic [5:0]  in_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_entry_count,
  output logic        out_read_valid,
  output logic [15:0] out_read_id,
  output logic [31:0] out_read_start,
  output logic [31:0] out_read_end,
  output logic        out_was_updated,
  output logic        out_was_evicted
);

  atwe_pkg::entry_t   in_item;
  atwe_pkg::mem_req_t mem_req;
  atwe_pkg::entry_t   mem_rdata;
  atwe_pkg::result_t  res;
  atwe_pkg::result_t  res_r;
  logic               res_done;
  logic               res_take;
  logic               out_valid_r;
  logic [32:0]        rel_sum;

  // relative add: start now, end saturates
  assign rel_sum = {1'b0, in_now} + {1'b0, in_duration};

  always_comb begin
    in_item.id = in_alarm_id;
    if (in_op == atwe_pkg::OP_ADD_REL) begin
      in_item.t_start = in_now;
      in_item.t_end   = rel_sum[32] ? atwe_pkg::TIME_MAX : rel_sum[31:0];
    end else begin
      in_item.t_start = in_start_time;
      in_item.t_end   = in_end_time;
    end
  end

  atwe_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  atwe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .in_item   (in_item),
    .in_now    (in_now),
    .in_index  (in_index),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_done  (res_done),
    .res       (res),
    .res_take  (res_take)
  );

  // output register frees the sequencer once the item is loaded
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_done;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_done) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_count = res_r.entry_count;
  assign out_read_valid  = res_r.read_valid;
  assign out_read_id     = res_r.rdat.id;
  assign out_read_start  = res_r.rdat.t_start;
  assign out_read_end    = res_r.rdat.t_end;
  assign out_was_updated = res_r.was_updated;
  assign out_was_evicted = res_r.was_evicted;

  `ATWE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted item did not hold off input")
  `ATWE_ASSERT_NOW(a_evict_when_full, out_valid && out_was_evicted, out_entry_count == 7'(atwe_pkg::ENTRIES), "eviction reported below full count")
  `ATWE_ASSERT_NOW(a_read_excl_add, out_valid && out_read_valid, !out_was_updated && !out_was_evicted && out_entry_count != 7'd0, "read result mixed with add flags")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the alarm table with expiry unit
`timescale 1ns / 1ps

module tb_top;

  // op codes that the block must treat as no-ops
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] id;
    logic [31:0] st;
    logic [31:0] en;
    logic [31:0] dur;
    logic [31:0] now;
    logic [5:0]  idx;
  } alarm_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op = '0;
  logic [15:0] in_alarm_id = '0;
  logic [31:0] in_start_time = '0;
  logic [31:0] in_end_time = '0;
  logic [31:0] in_duration = '0;
  logic [31:0] in_now = '0;
  logic [5:0]  in_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_entry_count;
  logic        out_read_valid;
  logic [15:0] out_read_id;
  logic [31:0] out_read_start;
  logic [31:0] out_read_end;
  logic        out_was_updated;
  logic        out_was_evicted;

  alarm_table_with_expiry_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_alarm_id     (in_alarm_id),
    .in_start_time   (in_start_time),
    .in_end_time     (in_end_time),
    .in_duration     (in_duration),
    .in_now          (in_now),
    .in_index        (in_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_entry_count (out_entry_count),
    .out_read_valid  (out_read_valid),
    .out_read_id     (out_read_id),
    .out_read_start  (out_read_start),
    .out_read_end    (out_read_end),
    .out_was_updated (out_was_updated),
    .out_was_evicted (out_was_evicted)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow alarm table
  atwe_pkg::entry_t  alarm_tab[atwe_pkg::ENTRIES];
  int                alarm_cnt;
  atwe_pkg::result_t pending_results[$];
  logic [31:0] sim_now;
  bit          steady_flow;
  int          n_errors;
  int          n_items;
  int          n_checked;
  int          n_updates;
  int          n_evictions;
  int          n_expired;
  int          n_read_hits;

  function automatic alarm_cmd_t make_cmd(logic [2:0] op, logic [15:0] id, logic [31:0] st,
                                          logic [31:0] en, logic [31:0] dur,
                                          logic [31:0] now, logic [5:0] idx);
    alarm_cmd_t c;
    c.op = op;
    c.id = id;
    c.st = st;
    c.en = en;
    c.dur = dur;
    c.now = now;
    c.idx = idx;
    return c;
  endfunction

  function automatic atwe_pkg::result_t apply_alarm_cmd(alarm_cmd_t c);
    atwe_pkg::result_t r;
    atwe_pkg::entry_t  e;
    logic [32:0] sum;
    int          hit;
    int          kept;
    r = '0;
    case (c.op) inside
      atwe_pkg::OP_ADD_ABS, atwe_pkg::OP_ADD_REL: begin
        e.id = c.id;
        if (c.op == atwe_pkg::OP_ADD_ABS) begin
          e.t_start = c.st;
          e.t_end = c.en;
        end else begin
          sum = {1'b0, c.now} + {1'b0, c.dur};
          e.t_start = c.now;
          e.t_end = sum[32] ? atwe_pkg::TIME_MAX : sum[31:0];
        end
        hit = -1;
        for (int i = 0; i < alarm_cnt; i++)
          if (hit < 0 && alarm_tab[i].id == c.id) hit = i;
        if (hit >= 0) begin
          alarm_tab[hit] = e;
          r.was_updated = 1'b1;
          n_updates++;
        end else begin
          if (alarm_cnt == atwe_pkg::ENTRIES) begin
            // drop the oldest and shift the rest down
            for (int i = 0; i < atwe_pkg::ENTRIES - 1; i++) alarm_tab[i] = alarm_tab[i + 1];
            alarm_cnt--;
            r.was_evicted = 1'b1;
            n_evictions++;
          end
          alarm_tab[alarm_cnt] = e;
          alarm_cnt++;
        end
      end
      atwe_pkg::OP_EXPIRE: begin
        kept = 0;
        for (int i = 0; i < alarm_cnt; i++)
          if (c.now <= alarm_tab[i].t_end) begin
            alarm_tab[kept] = alarm_tab[i];
            kept++;
          end
        n_expired += alarm_cnt - kept;
        alarm_cnt = kept;
      end
      atwe_pkg::OP_READ: begin
        if (int'(c.idx) < alarm_cnt) begin
          r.read_valid = 1'b1;
          r.rdat = alarm_tab[c.idx];
          n_read_hits++;
        end
      end
      atwe_pkg::OP_CLEAR: alarm_cnt = 0;
      default: ;
    endcase
    r.entry_count = atwe_pkg::OUT_CNT_W'(alarm_cnt);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    n_errors++;
  endtask

  task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // hold a new item on the input until it is taken, then predict its result
  task automatic send_item(alarm_cmd_t c);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= c.op;
    in_alarm_id   <= c.id;
    in_start_time <= c.st;
    in_end_time   <= c.en;
    in_duration   <= c.dur;
    in_now        <= c.now;
    in_index      <= c.idx;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(apply_alarm_cmd(c));
    n_items++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic make_random_cmd(output alarm_cmd_t c);
    int pick;
    int span;
    sim_now += $urandom_range(0, 40);
    pick = $urandom_range(0, 99);
    if (pick < 30)      c.op = atwe_pkg::OP_ADD_ABS;
    else if (pick < 55) c.op = atwe_pkg::OP_ADD_REL;
    else if (pick < 67) c.op = atwe_pkg::OP_EXPIRE;
    else if (pick < 93) c.op = atwe_pkg::OP_READ;
    else if (pick < 95) c.op = atwe_pkg::OP_CLEAR;
    else if (pick < 97) c.op = OP_SPARE_5;
    else if (pick < 98) c.op = OP_SPARE_6;
    else                c.op = OP_SPARE_7;
    // a small id pool gives frequent updates, full range gives fills
    c.id = $urandom_range(0, 1) ? 16'($urandom_range(0, 23)) : 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 5)      span = $urandom_range(0, 60);
    else if (pick < 9) span = $urandom_range(0, 5000);
    else               span = $urandom;
    c.dur = 32'(span);
    c.en  = ($urandom_range(0, 9) == 0) ? 32'($urandom) : sim_now + 32'(span);
    c.st  = ($urandom_range(0, 9) == 0) ? 32'($urandom) : sim_now - $urandom_range(0, 100);
    c.now = ($urandom_range(0, 9) == 0) ? 32'($urandom) : sim_now;
    if (alarm_cnt > 0 && $urandom_range(0, 4) != 0)
      c.idx = 6'($urandom_range(0, alarm_cnt - 1));
    else
      c.idx = 6'($urandom_range(0, 63));
  endtask

  task automatic test_corner_cases();
    send_item(make_cmd(atwe_pkg::OP_READ, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 6'd0));
    send_item(make_cmd(atwe_pkg::OP_CLEAR, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 6'd0));
    send_item(make_cmd(atwe_pkg::OP_EXPIRE, 16'd0, 32'd0, 32'd0, 32'd0,
                       atwe_pkg::TIME_MAX, 6'd0));
    send_item(make_cmd(OP_SPARE_5, 16'hFFFF, atwe_pkg::TIME_MAX, atwe_pkg::TIME_MAX,
                       atwe_pkg::TIME_MAX, atwe_pkg::TIME_MAX, 6'h3F));
    send_item(make_cmd(OP_SPARE_6, 16'hFFFF, atwe_pkg::TIME_MAX, atwe_pkg::TIME_MAX,
                       atwe_pkg::TIME_MAX, atwe_pkg::TIME_MAX, 6'h3F));
    send_item(make_cmd(OP_SPARE_7, 16'hFFFF, atwe_pkg::TIME_MAX, atwe_pkg::TIME_MAX,
                       atwe_pkg::TIME_MAX, atwe_pkg::TIME_MAX, 6'h3F));
    send_item(make_cmd(atwe_pkg::OP_ADD_ABS, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 6'd0));
    send_item(make_cmd(atwe_pkg::OP_ADD_ABS, 16'hFFFF, atwe_pkg::TIME_MAX,
                       atwe_pkg::TIME_MAX, 32'd0, 32'd0, 6'd0));
    // end time saturates
    send_item(make_cmd(atwe_pkg::OP_ADD_REL, 16'd1, 32'd0, 32'd0, atwe_pkg::TIME_MAX,
                       32'hFFFF_FFF0, 6'd0));
    send_item(make_cmd(atwe_pkg::OP_ADD_REL, 16'd2, 32'd0, 32'd0, 32'd0, 32'd5, 6'd0));
    // update in place, position kept
    send_item(make_cmd(atwe_pkg::OP_ADD_ABS, 16'd0, 32'd3, 32'd7, 32'd0, 32'd0, 6'd0));
    send_item(make_cmd(atwe_pkg::OP_ADD_REL, 16'hFFFF, 32'd0, 32'd0, 32'd1, 32'd9, 6'd0));
    send_item(make_cmd(atwe_pkg::OP_READ, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 6'd0));
    send_item(make_cmd(atwe_pkg::OP_READ, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 6'd3));
    send_item(make_cmd(atwe_pkg::OP_READ, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 6'd4));
    send_item(make_cmd(atwe_pkg::OP_READ, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 6'h3F));
    // end equal to now survives, one past it does not
    send_item(make_cmd(atwe_pkg::OP_EXPIRE, 16'd0, 32'd0, 32'd0, 32'd0, 32'd5, 6'd0));
    send_item(make_cmd(atwe_pkg::OP_EXPIRE, 16'd0, 32'd0, 32'd0, 32'd0, 32'd6, 6'd0));
    send_item(make_cmd(atwe_pkg::OP_READ, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 6'd2));
    send_item(make_cmd(atwe_pkg::OP_CLEAR, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 6'd0));
    send_item(make_cmd(atwe_pkg::OP_READ, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 6'd0));
  endtask

  task automatic test_overflow_eviction();
    alarm_cmd_t c;
    for (int run = 0; run < 3; run++) begin
      sim_now = $urandom_range(0, 100000);
      send_item(make_cmd(atwe_pkg::OP_CLEAR, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 6'd0));
      repeat ($urandom_range(atwe_pkg::ENTRIES + 2, atwe_pkg::ENTRIES + 14)) begin
        make_random_cmd(c);
        c.op = $urandom_range(0, 1) ? atwe_pkg::OP_ADD_ABS : atwe_pkg::OP_ADD_REL;
        c.id = 16'($urandom);
        send_item(c);
      end
      for (int k = 0; k <= atwe_pkg::ENTRIES; k++) begin
        make_random_cmd(c);
        c.op = atwe_pkg::OP_READ;
        c.idx = 6'(k);
        send_item(c);
      end
      make_random_cmd(c);
      c.op = atwe_pkg::OP_EXPIRE;
      send_item(c);
    end
  endtask

  task automatic test_mixed_traffic(int n, logic [31:0] base);
    alarm_cmd_t c;
    sim_now = base;
    for (int i = 0; i < n; i++) begin
      // alternate stretches with and without idle cycles
      if (i % 64 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      make_random_cmd(c);
      send_item(c);
    end
    steady_flow = 1'b0;
  endtask

  // consumer side: stall for a random time on each result, but not in steady flow
  always begin : result_sink
    int hold;
    hold = steady_flow ? 0 : $urandom_range(0, 10);
    if (hold > 0) begin
      out_stall <= 1'b1;
      while (hold > 0) begin
        @(posedge clk);
        if (out_valid === 1'b1) hold--;
      end
      out_stall <= 1'b0;
    end
    do @(posedge clk); while (out_valid !== 1'b1);
  end

  always @(posedge clk) begin : result_check
    atwe_pkg::result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'd1, 32'd0);
      end else begin
        want = pending_results.pop_front();
        compare_field("entry_count", 32'(out_entry_count), 32'(want.entry_count));
        compare_field("read_valid", 32'(out_read_valid), 32'(want.read_valid));
        compare_field("read_id", 32'(out_read_id), 32'(want.rdat.id));
        compare_field("read_start", out_read_start, want.rdat.t_start);
        compare_field("read_end", out_read_end, want.rdat.t_end);
        compare_field("was_updated", 32'(out_was_updated), 32'(want.was_updated));
        compare_field("was_evicted", 32'(out_was_evicted), 32'(want.was_evicted));
        n_checked++;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results still pending", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    alarm_cnt = 0;
    steady_flow = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_corner_cases();
    wait_for_drain();
    test_overflow_eviction();
    test_mixed_traffic(450, 32'd1000);
    wait_for_drain();
    test_mixed_traffic(400, 32'hFFFF_8000);
    wait_for_drain();
    // catch any stray result after the last one
    repeat (4 * atwe_pkg::ENTRIES + 40) @(posedge clk);
    $display("Sent %0d items, checked %0d results, %0d mismatches.",
             n_items, n_checked, n_errors);
    $display("Table activity: %0d updates, %0d evictions, %0d expired, %0d reads in range.",
             n_updates, n_evictions, n_expired, n_read_hits);
    if (n_errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== alarm_table_with_expiry_unit.f =====
+incdir+src
src/atwe_pkg.sv
src/atwe_mem.sv
src/atwe_ctrl.sv
src/alarm_table_with_expiry_unit.sv
test/tb_top.sv
